[rtl/mcn_pkg.sv]
// ----------------------------------------------------------------------------
// Month calendar navigator package
// Shared types, constants and the month table for the calendar navigator.
// ----------------------------------------------------------------------------
package mcn_pkg;

   // Action codes carried in the request tuser field.
   typedef enum logic [1:0] {
      ACT_SET  = 2'd0,
      ACT_NEXT = 2'd1,
      ACT_PREV = 2'd2
   } action_type;

   localparam int unsigned YearWidth  = 14;
   localparam int unsigned MonthWidth = 4;

   localparam logic [YearWidth-1:0]  YearMin  = 14'd1;
   localparam logic [YearWidth-1:0]  YearMax  = 14'd9999;
   localparam logic [MonthWidth-1:0] MonthJan = 4'd1;
   localparam logic [MonthWidth-1:0] MonthFeb = 4'd2;
   localparam logic [MonthWidth-1:0] MonthDec = 4'd12;
   localparam logic [MonthWidth-1:0] MonthsPerYear = 4'd12;

   // Year divided by 100 as a multiply by 5243 and a shift by 19, exact below 10000.
   localparam int unsigned Div100Mul   = 5243;
   localparam int unsigned Div100Shift = 19;

   // Fields handed from the split stage to the weekday stage.
   typedef struct packed {
      logic [YearWidth-1:0]  year;       // current year
      logic [MonthWidth-1:0] month;      // current month, 1 is January
      logic [MonthWidth-1:0] month_ext;  // 13 and 14 stand for January and February
      logic [6:0]            cent;       // century of the adjusted year
      logic [6:0]            yoc;        // year of century of the adjusted year
   } date_stage_type;

   // Month term of the congruence, floor(26 * (m + 1) / 10), for months 3 to 14.
   function automatic logic [5:0] month_term(input logic [MonthWidth-1:0] m);
      logic [5:0] t;
      unique case (m)
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd13;
         4'd5:    t = 6'd15;
         4'd6:    t = 6'd18;
         4'd7:    t = 6'd20;
         4'd8:    t = 6'd23;
         4'd9:    t = 6'd26;
         4'd10:   t = 6'd28;
         4'd11:   t = 6'd31;
         4'd12:   t = 6'd33;
         4'd13:   t = 6'd36;
         4'd14:   t = 6'd39;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

endpackage

[rtl/mcn_date_calc.sv]
// ----------------------------------------------------------------------------
// Month calendar navigator date calculation
// Weekday of the first day and length of the month from the split year.
// ----------------------------------------------------------------------------
module mcn_date_calc (
   input  mcn_pkg::date_stage_type stage_i,
   output logic [2:0]              first_weekday_o,
   output logic [4:0]              month_length_o
);

   logic [9:0] sum;
   logic [4:0] fold_a;
   logic [3:0] fold_b;
   logic       leap;

   // The congruence sum stays below 1024, so it fits ten bits.
   assign sum = 10'(stage_i.yoc) + 10'(stage_i.yoc[6:2]) + 10'(stage_i.cent[6:2])
              + 10'(stage_i.cent) * 10'd5 + 10'(mcn_pkg::month_term(stage_i.month_ext));

   // Since 8 is 1 modulo 7, octal digits can be summed to reduce the value.
   assign fold_a = 5'(sum[2:0]) + 5'(sum[5:3]) + 5'(sum[8:6]) + 5'(sum[9]);
   assign fold_b = 4'(fold_a[2:0]) + 4'(fold_a[4:3]);
   assign first_weekday_o = (fold_b >= 4'd7) ? 3'(fold_b - 4'd7) : fold_b[2:0];

   // In February the adjusted year is one less than the year, so the year is a
   // century year exactly when the adjusted year ends in 99, and its century
   // is then one more than the stored century.
   assign leap = (stage_i.year[1:0] == 2'd0) &&
                 ((stage_i.yoc != 7'd99) || (stage_i.cent[1:0] == 2'd3));

   always_comb begin
      unique case (stage_i.month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_length_o = 5'd31;
         mcn_pkg::MonthFeb: month_length_o = leap ? 5'd29 : 5'd28;
         default:           month_length_o = 5'd30;
      endcase
   end

endmodule

[rtl/month_calendar_navigator.sv]
// ----------------------------------------------------------------------------
// Month calendar navigator
// Steps a Gregorian year and month and reports weekday and month length.
// ----------------------------------------------------------------------------
// The request channel carries one item per command: tuser holds the action
// (set, next month, previous month) and tdata holds the year and month that a
// set loads. Each item moves the current year and month, which reset places at
// January 2000. Out-of-range set values are clamped, stepping wraps December
// and January into the year, and the year holds at 1 and at 9999.
// Every item returns exactly one item on the response channel: the year and
// month after the command, the weekday of the month's first day (0 is Sunday)
// and the number of days in the month.
// On its way to rsp_tvalid an item passes the state register, which updates at
// acceptance, a split stage, which registers century and year of century, and
// the result register, which holds the finished item. Throughput is one item
// per cycle unless the receiver stalls; the state update is a single load,
// increment or decrement, so consecutive items never wait on each other.
// When the receiver stalls, the three stages fill and req_tready drops only
// once all of them hold an item. Reset empties the pipeline.
// ----------------------------------------------------------------------------
module month_calendar_navigator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // set_year [13:0], set_month [17:14], zeros
   input  logic [1:0]  req_tuser,   // action [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // year_now [13:0], month_now [17:14],
                                    // first_weekday [20:18], month_length [25:21], zeros
);

   // Pipeline valid flags: state stage, split stage, result stage.
   logic s1_vld_ff, s1_vld_in;
   logic s2_vld_ff, s2_vld_in;
   logic rsp_vld_ff, rsp_vld_in;

   // Calendar state.
   logic [13:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;

   // Split stage and result payload.
   mcn_pkg::date_stage_type s2_ff, s2_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic out_free, s2_free, s1_free, req_accept;

   mcn_pkg::action_type action;
   logic [13:0] set_year;
   logic [3:0]  set_month;

   logic        early;
   logic [13:0] year_adj;
   logic [26:0] div_prod;
   logic [6:0]  cent;
   logic [2:0]  first_weekday;
   logic [4:0]  month_length;

   // Each stage can take a new item when it is empty or its item moves on.
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign s2_free    = !s2_vld_ff || out_free;
   assign s1_free    = !s1_vld_ff || s2_free;
   assign req_tready = s1_free;
   assign req_accept = req_tvalid && req_tready;

   assign action    = mcn_pkg::action_type'(req_tuser[1:0]);
   assign set_year  = req_tdata[13:0];
   assign set_month = req_tdata[17:14];

   // Next calendar state for the accepted item.
   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      if (req_accept) begin
         unique case (action)
            mcn_pkg::ACT_SET: begin
               priority if (set_year < mcn_pkg::YearMin) year_in = mcn_pkg::YearMin;
               else if (set_year > mcn_pkg::YearMax)     year_in = mcn_pkg::YearMax;
               else                                      year_in = set_year;
               priority if (set_month < mcn_pkg::MonthJan) month_in = mcn_pkg::MonthJan;
               else if (set_month > mcn_pkg::MonthDec)     month_in = mcn_pkg::MonthDec;
               else                                        month_in = set_month;
            end
            mcn_pkg::ACT_NEXT: begin
               if (month_ff >= mcn_pkg::MonthDec) begin
                  if (year_ff < mcn_pkg::YearMax) begin
                     year_in  = 14'(year_ff + 14'd1);
                     month_in = mcn_pkg::MonthJan;
                  end
               end else begin
                  month_in = 4'(month_ff + 4'd1);
               end
            end
            mcn_pkg::ACT_PREV: begin
               if (month_ff <= mcn_pkg::MonthJan) begin
                  if (year_ff > mcn_pkg::YearMin) begin
                     year_in  = 14'(year_ff - 14'd1);
                     month_in = mcn_pkg::MonthDec;
                  end
               end else begin
                  month_in = 4'(month_ff - 4'd1);
               end
            end
            default: begin
               // The unused action code leaves the state as it is.
            end
         endcase
      end
   end

   // January and February count as months 13 and 14 of the previous year.
   // The adjusted year is then split into century and year of century.
   assign early    = (month_ff <= mcn_pkg::MonthFeb);
   assign year_adj = early ? 14'(year_ff - 14'd1) : year_ff;
   assign div_prod = 27'(year_adj) * 27'(mcn_pkg::Div100Mul);
   assign cent     = div_prod[mcn_pkg::Div100Shift +: 7];

   always_comb begin
      s2_in = s2_ff;
      if (s1_vld_ff && s2_free) begin
         s2_in.year      = year_ff;
         s2_in.month     = month_ff;
         s2_in.month_ext = early ? 4'(month_ff + mcn_pkg::MonthsPerYear) : month_ff;
         s2_in.cent      = cent;
         s2_in.yoc       = 7'(year_adj - 14'(cent) * 14'd100);
      end
   end

   mcn_date_calc u_date_calc (
      .stage_i         (s2_ff),
      .first_weekday_o (first_weekday),
      .month_length_o  (month_length)
   );

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (s2_vld_ff && out_free) begin
         rsp_data_in = {6'd0, month_length, first_weekday, s2_ff.month, s2_ff.year};
      end
   end

   assign s1_vld_in  = s1_free  ? req_accept : s1_vld_ff;
   assign s2_vld_in  = s2_free  ? s1_vld_ff  : s2_vld_ff;
   assign rsp_vld_in = out_free ? s2_vld_ff  : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         year_ff    <= 14'd2000;
         month_ff   <= mcn_pkg::MonthJan;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         year_ff    <= year_in;
         month_ff   <= month_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff       <= s2_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The calendar state never leaves the supported range.
   a_year_range: assert property (@(posedge clock) disable iff (reset)
      (year_ff >= mcn_pkg::YearMin) && (year_ff <= mcn_pkg::YearMax))
      else $error("current year out of range");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (month_ff >= mcn_pkg::MonthJan) && (month_ff <= mcn_pkg::MonthDec))
      else $error("current month out of range");

   // A next-month step inside a year advances the month by one.
   a_next_step: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (action == mcn_pkg::ACT_NEXT) && (month_ff < mcn_pkg::MonthDec))
      |=> (month_ff == 4'($past(month_ff) + 4'd1)) && $stable(year_ff))
      else $error("next-month step did not advance the month");

   // A finished item always reports a legal weekday and month length.
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_data_ff[20:18] <= 3'd6) &&
                     (rsp_data_ff[25:21] >= 5'd28) && (rsp_data_ff[25:21] <= 5'd31))
      else $error("result weekday or month length out of range");

   // An item leaving the split stage lands in the result register.
   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      (s2_vld_ff && out_free) |=> rsp_vld_ff)
      else $error("item lost between split stage and result register");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Month calendar navigator testbench
// Drives set, next-month, previous-month and unused commands into the request
// stream with random sender gaps and receiver stalls. A scoreboard keeps its
// own copy of the current year and month and predicts every response item:
// year, month, weekday of the first day and month length.
// ----------------------------------------------------------------------------
module testbench;

   // The fourth action code leaves the date unchanged.
   localparam logic [1:0] ActUnused = 2'd3;

   // Cycles without any accepted item before the run is declared hung.
   localparam int unsigned HangLimit = 2000;

   // Cycles allowed after the last response for anything stray to appear.
   localparam int unsigned DrainCycles = 8;

   localparam int unsigned ItemsPerPhase = 310;

   // One response item, split into its fields.
   typedef struct {
      logic [13:0] year_now;
      logic [3:0]  month_now;
      logic [2:0]  first_weekday;
      logic [4:0]  month_length;
   } calendar_view_type;

   // Tracks the calendar state and holds the responses that are still owed.
   class calendar_scoreboard;
      int unsigned       year_q;
      int unsigned       month_q;
      calendar_view_type owed_views[$];
      int unsigned       failures;

      function new();
         year_q   = 2000;
         month_q  = mcn_pkg::MonthJan;
         failures = 0;
      endfunction

      function bit leap_year(int unsigned yr);
         return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      endfunction

      // Zeller's congruence for day one; January and February belong to the
      // year before as months 13 and 14. Minus twice the century is taken as
      // plus five times, which agrees modulo seven.
      function int unsigned weekday_of_first(int unsigned yr, int unsigned mo);
         int unsigned y_adj;
         int unsigned m_adj;
         int unsigned yoc;
         int unsigned cent;
         y_adj = (mo <= mcn_pkg::MonthFeb) ? yr - 1 : yr;
         m_adj = (mo <= mcn_pkg::MonthFeb) ? mo + 12 : mo;
         yoc   = y_adj % 100;
         cent  = y_adj / 100;
         return (yoc + yoc / 4 + cent / 4 + 5 * cent + (26 * (m_adj + 1)) / 10) % 7;
      endfunction

      function int unsigned days_in_month(int unsigned yr, int unsigned mo);
         case (mo)
            4, 6, 9, 11: return 30;
            2:           return leap_year(yr) ? 29 : 28;
            default:     return 31;
         endcase
      endfunction

      function int unsigned pending();
         return owed_views.size();
      endfunction

      // Applies one accepted command and queues the response it owes.
      function void note_request(logic [1:0] act, logic [13:0] yr, logic [3:0] mo);
         calendar_view_type view;
         int unsigned       y_in;
         int unsigned       m_in;
         y_in = 32'(yr);
         m_in = 32'(mo);
         case (act)
            mcn_pkg::ACT_SET: begin
               year_q  = (y_in < mcn_pkg::YearMin) ? mcn_pkg::YearMin
                       : (y_in > mcn_pkg::YearMax) ? mcn_pkg::YearMax : y_in;
               month_q = (m_in < mcn_pkg::MonthJan) ? mcn_pkg::MonthJan
                       : (m_in > mcn_pkg::MonthDec) ? mcn_pkg::MonthDec : m_in;
            end
            mcn_pkg::ACT_NEXT: begin
               if (month_q >= mcn_pkg::MonthDec) begin
                  if (year_q < mcn_pkg::YearMax) begin
                     year_q  = year_q + 1;
                     month_q = mcn_pkg::MonthJan;
                  end
               end else begin
                  month_q = month_q + 1;
               end
            end
            mcn_pkg::ACT_PREV: begin
               if (month_q <= mcn_pkg::MonthJan) begin
                  if (year_q > mcn_pkg::YearMin) begin
                     year_q  = year_q - 1;
                     month_q = mcn_pkg::MonthDec;
                  end
               end else begin
                  month_q = month_q - 1;
               end
            end
            default: begin
            end
         endcase
         view.year_now      = 14'(year_q);
         view.month_now     = 4'(month_q);
         view.first_weekday = 3'(weekday_of_first(year_q, month_q));
         view.month_length  = 5'(days_in_month(year_q, month_q));
         owed_views.insert(owed_views.size(), view);
      endfunction

      // Compares one accepted response with the oldest owed view.
      function void check_result(logic [31:0] data);
         calendar_view_type want;
         if (owed_views.size() == 0) begin
            $error("response item with nothing owed: 0x%08h", data);
            failures++;
            return;
         end
         want = owed_views.pop_front();
         if (data[13:0] !== want.year_now) begin
            $error("year_now: expected %0d, actual %0d", want.year_now, data[13:0]);
            failures++;
         end
         if (data[17:14] !== want.month_now) begin
            $error("month_now: expected %0d, actual %0d", want.month_now, data[17:14]);
            failures++;
         end
         if (data[20:18] !== want.first_weekday) begin
            $error("first_weekday: expected %0d, actual %0d",
                   want.first_weekday, data[20:18]);
            failures++;
         end
         if (data[25:21] !== want.month_length) begin
            $error("month_length: expected %0d, actual %0d",
                   want.month_length, data[25:21]);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // set_year [13:0], set_month [17:14], zeros
   logic [1:0]  req_tuser;   // action [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // year_now [13:0], month_now [17:14],
                             // first_weekday [20:18], month_length [25:21], zeros

   calendar_scoreboard sb;

   // Percent chance per cycle that the sender idles or the receiver stalls.
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned quiet_cycles;

   month_calendar_navigator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // The receiver decides afresh each cycle whether to stall.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Both handshakes are sampled at the edge. The response is checked before
   // the request is noted, because a response accepted at this edge can only
   // belong to an earlier command.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
         end
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tuser, req_tdata[13:0], req_tdata[17:14]);
         end
      end
   end

   // Hang detection: any accepted item on either side resets the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HangLimit) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one command, holds it until it is taken, then idles the sender
   // for a random number of cycles. Valid stays high across back-to-back items.
   task automatic send_command(input logic [1:0] act, input logic [13:0] yr,
                               input logic [3:0] mo);
      req_tuser  <= act;
      req_tdata  <= {6'd0, mo, yr};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Holds the sender off until every owed response has arrived. The queue
   // is looked at on the falling edge, away from the sampling edge.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Mostly month steps from well-chosen starting points, so that walks cross
   // year ends, Februaries and both saturation limits. Ignored data fields of
   // step commands carry random bits.
   task automatic send_random_command();
      int unsigned pick;
      logic [13:0] junk_year;
      logic [3:0]  junk_month;
      pick       = $urandom_range(99);
      junk_year  = 14'($urandom_range(16383));
      junk_month = 4'($urandom_range(15));
      if (pick < 8) begin
         send_command(mcn_pkg::ACT_SET, 14'($urandom_range(9999, 1)),
                      4'($urandom_range(12, 1)));
      end else if (pick < 11) begin
         // Near the year limits, at the month ends.
         send_command(mcn_pkg::ACT_SET,
                      14'($urandom_range(1) ? $urandom_range(3, 1)
                                            : $urandom_range(9999, 9997)),
                      4'($urandom_range(1) ? $urandom_range(2, 1)
                                           : $urandom_range(12, 11)));
      end else if (pick < 14) begin
         // Century years, where the leap rule has its exceptions.
         send_command(mcn_pkg::ACT_SET, 14'(100 * $urandom_range(99, 1)),
                      4'($urandom_range(3, 1)));
      end else if (pick < 17) begin
         // Raw field values, out-of-range ones included.
         send_command(mcn_pkg::ACT_SET, junk_year, junk_month);
      end else if (pick < 20) begin
         send_command(ActUnused, junk_year, junk_month);
      end else if (pick < 60) begin
         send_command(mcn_pkg::ACT_NEXT, junk_year, junk_month);
      end else begin
         send_command(mcn_pkg::ACT_PREV, junk_year, junk_month);
      end
   endtask

   initial begin
      int unsigned idle_plan [4];
      int unsigned stall_plan[4];
      idle_plan  = '{0, 62, 0, 25};
      stall_plan = '{0, 0, 62, 25};
      sb         = new();
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = mcn_pkg::ACT_SET;
      rsp_tready = 1'b0;
      idle_pct   = 0;
      stall_pct  = 0;
      quiet_cycles = 0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed commands. The first step starts from the reset date and
      // lands on a leap February.
      send_command(mcn_pkg::ACT_NEXT, 14'd0, 4'd0);
      send_command(ActUnused, 14'h3fff, 4'hf);
      // Set values below range clamp to January of year one.
      send_command(mcn_pkg::ACT_SET, 14'd0, 4'd0);
      // Stepping back from January of year one holds there.
      send_command(mcn_pkg::ACT_PREV, 14'h3fff, 4'hf);
      send_command(mcn_pkg::ACT_NEXT, 14'h2aaa, 4'ha);
      // Set values above range clamp to December 9999.
      send_command(mcn_pkg::ACT_SET, 14'h3fff, 4'hf);
      // Stepping on from December 9999 holds there.
      send_command(mcn_pkg::ACT_NEXT, 14'h1555, 4'h5);
      send_command(mcn_pkg::ACT_PREV, 14'd0, 4'd0);
      send_command(mcn_pkg::ACT_SET, 14'd9999, 4'd12);
      send_command(mcn_pkg::ACT_SET, 14'd10000, 4'd13);
      // Leap rule: divisible by 100 but not 400, by 400, by 4, and not by 4.
      send_command(mcn_pkg::ACT_SET, 14'd1900, 4'd2);
      send_command(mcn_pkg::ACT_SET, 14'd2000, 4'd2);
      send_command(mcn_pkg::ACT_SET, 14'd2004, 4'd2);
      send_command(mcn_pkg::ACT_SET, 14'd2100, 4'd2);
      send_command(mcn_pkg::ACT_SET, 14'd2023, 4'd2);
      // Year end wrap in both directions.
      send_command(mcn_pkg::ACT_SET, 14'd2023, 4'd12);
      send_command(mcn_pkg::ACT_NEXT, 14'd0, 4'd0);
      send_command(mcn_pkg::ACT_PREV, 14'd0, 4'd0);
      // February of year one, whose adjusted year is zero.
      send_command(mcn_pkg::ACT_SET, 14'd1, 4'd2);
      send_command(mcn_pkg::ACT_SET, 14'd1, 4'd1);
      send_command(ActUnused, 14'd0, 4'd0);
      send_command(mcn_pkg::ACT_SET, 14'h2aaa, 4'h5);
      send_command(mcn_pkg::ACT_SET, 14'h1555, 4'ha);

      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = idle_plan[phase];
         stall_pct = stall_plan[phase];
         for (int n = 0; n < ItemsPerPhase; n++) begin
            // Once per phase, let the pipeline run dry before going on.
            if (n == ItemsPerPhase / 2) begin
               wait_for_drain();
            end
            send_random_command();
         end
      end

      wait_for_drain();
      repeat (DrainCycles) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/mcn_pkg.sv
rtl/mcn_date_calc.sv
rtl/month_calendar_navigator.sv
tb/testbench.sv
